// ----- sv/lcgbr_pkg.sv -----
// Shared constants and helpers for the 48-bit LCG bounded random unit.
// No dependencies; used by the multiply step unit and the top level.
`default_nettype none

package lcgbr_pkg;

   // Generator constants
   localparam logic [47:0] LCG_MULT   = 48'h0005_DEEC_E66D;
   localparam logic [47:0] LCG_INC    = 48'h0000_0000_000B;
   localparam int          STATE_W    = 48;
   localparam int          CHUNK_W    = 12;
   localparam int          MUL_STEPS  = 3;
   localparam int          DRAW_W     = 31;
   localparam int          FRAC_W     = 24;
   localparam logic [23:0] FRAC_HALF  = 24'h80_0000;

   // Request operation codes
   localparam logic [1:0] OP_RESEED = 2'd0;
   localparam logic [1:0] OP_INT    = 2'd1;
   localparam logic [1:0] OP_FRAC   = 2'd2;
   localparam logic [1:0] OP_BOOL   = 2'd3;

   // 12-bit slice of the multiplier constant, least significant first
   function automatic logic [CHUNK_W-1:0] mult_chunk(input logic [1:0] idx);
      logic [CHUNK_W-1:0] chunk;
      unique case (idx)
         2'd0:    chunk = 12'h66D;
         2'd1:    chunk = 12'hECE;
         2'd2:    chunk = 12'h5DE;
         default: chunk = 12'h000;
      endcase
      return chunk;
   endfunction

endpackage

`default_nettype wire

// ----- sv/lcgbr_mul.sv -----
// Iterative LCG advance: state * multiplier + increment, mod 2^48.
// Depends on lcgbr_pkg; one 48x12 partial product per cycle, one per constant slice.
`default_nettype none

module lcgbr_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] state_in,
   output logic             done,
   output logic [47:0]      state_out
);

   logic [47:0] acc_ff, acc_in;
   logic [47:0] mcand_ff, mcand_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [59:0] pp;

   // Partial product of the shifted multiplicand and one constant slice
   assign pp = mcand_ff * {48'd0, lcgbr_pkg::mult_chunk(cnt_ff)};

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = lcgbr_pkg::LCG_INC;
         mcand_in = state_in;
         cnt_in   = 2'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in   = acc_ff + pp[47:0];
         mcand_in = {mcand_ff[47-lcgbr_pkg::CHUNK_W:0], {lcgbr_pkg::CHUNK_W{1'b0}}};
         cnt_in   = cnt_ff + 2'd1;
         if (cnt_ff == 2'(lcgbr_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
   end

   assign done      = done_ff;
   assign state_out = acc_ff;

endmodule

`default_nettype wire

// ----- sv/lcgbr_div.sv -----
// Restoring remainder unit: 31-bit dividend mod 31-bit divisor, one bit a cycle.
// No package dependency; done is raised once the last dividend bit has been processed.
`default_nettype none

module lcgbr_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [30:0] dividend,
   input  wire logic [30:0] divisor,
   output logic             done,
   output logic [30:0]      remainder
);

   logic [30:0] rem_ff, rem_in;
   logic [30:0] dvd_ff, dvd_in;
   logic [30:0] dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] trial;
   logic [31:0] diff;

   // Bring down the next dividend bit and try the subtraction
   assign trial = {rem_ff, dvd_ff[30]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = 31'd0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[31] ? trial[30:0] : diff[30:0];
         dvd_in = {dvd_ff[29:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- sv/lcg48_bounded_random_unit.sv -----
// 48-bit LCG random unit with bounded integer, fraction and boolean draws.
// Depends on lcgbr_pkg, lcgbr_mul and lcgbr_div.
//
// One request at a time. A reseed, or an integer draw whose bound
// (range_max - range_min, wrapped) is negative, goes straight to the
// finish state. A fraction or boolean draw first advances the generator
// in the multiply step unit. A power-of-two or zero bound advances the
// generator and then scales the draw bits by the bound. Any other bound
// advances the generator, then reduces the draw bits in the bit-serial
// remainder unit, and each rejected attempt runs a fresh advance and
// remainder. A finished response sits in its output register while the
// next request is accepted; if that register is still held by rsp_ready
// low when the next result is ready, the unit waits.
`default_nettype none

module lcg48_bounded_random_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [31:0] req_seed_value,
   input  wire logic signed [31:0] req_range_min,
   input  wire logic signed [31:0] req_range_max,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_int_result,
   output logic [23:0]             rsp_fraction,
   output logic                    rsp_bool_result,
   output logic                    rsp_error
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ADV  = 3'd1;
   localparam logic [2:0] ST_POW  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [47:0] lcg_ff, lcg_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] n_ff, n_in;
   logic [30:0] bits_ff, bits_in;
   logic [31:0] ires_ff, ires_in;
   logic [23:0] frac_ff, frac_in;
   logic        bres_ff, bres_in;
   logic        err_ff, err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        div_go_ff, div_go_in;
   logic [31:0] out_int_ff;
   logic [23:0] out_frac_ff;
   logic        out_bool_ff, out_err_ff;

   logic        mul_start, mul_done;
   logic [47:0] mul_result;
   logic        div_start, div_done;
   logic [30:0] div_rem;

   logic [31:0] req_n;
   logic        n_pow2;
   logic [61:0] pow_prod;
   logic [31:0] rej_test;
   logic        load_out;

   lcgbr_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .state_in  (lcg_ff),
      .done      (mul_done),
      .state_out (mul_result)
   );

   lcgbr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (bits_ff),
      .divisor   (n_ff[30:0]),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Bound arithmetic
   assign req_n    = req_range_max - req_range_min;
   assign n_pow2   = ((n_ff & (n_ff - 32'd1)) == 32'd0);
   assign pow_prod = n_ff[30:0] * bits_ff;
   assign rej_test = {1'b0, bits_ff} - {1'b0, div_rem} + n_ff - 32'd1;

   assign req_ready = (state_ff == ST_IDLE);
   assign load_out  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      lcg_in       = lcg_ff;
      op_in        = op_ff;
      lo_in        = lo_ff;
      n_in         = n_ff;
      bits_in      = bits_ff;
      ires_in      = ires_ff;
      frac_in      = frac_ff;
      bres_in      = bres_ff;
      err_in       = err_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_operation;
               lo_in   = req_range_min;
               n_in    = req_n;
               ires_in = 32'd0;
               frac_in = 24'd0;
               bres_in = 1'b0;
               err_in  = 1'b0;
               priority if (req_operation == lcgbr_pkg::OP_RESEED) begin
                  lcg_in   = {{16{req_seed_value[31]}}, req_seed_value}
                             ^ lcgbr_pkg::LCG_MULT;
                  state_in = ST_FIN;
               end else if (req_operation == lcgbr_pkg::OP_INT && req_n[31]) begin
                  err_in   = 1'b1;
                  ires_in  = req_range_min;
                  state_in = ST_FIN;
               end else begin
                  mul_start = 1'b1;
                  state_in  = ST_ADV;
               end
            end
         end
         ST_ADV: begin
            if (mul_done) begin
               lcg_in  = mul_result;
               bits_in = mul_result[47:17];
               if (op_ff == lcgbr_pkg::OP_INT) begin
                  state_in = n_pow2 ? ST_POW : ST_DIV;
               end else begin
                  frac_in  = mul_result[47:24];
                  bres_in  = (op_ff == lcgbr_pkg::OP_BOOL) &&
                             (mul_result[47:24] > lcgbr_pkg::FRAC_HALF);
                  state_in = ST_FIN;
               end
            end
         end
         ST_POW: begin
            ires_in  = lo_ff + {1'b0, pow_prod[61:31]};
            state_in = ST_FIN;
         end
         ST_DIV: begin
            // Kick the divider on entry, then wait for the remainder
            if (div_done) begin
               if (rej_test[31]) begin
                  mul_start = 1'b1;
                  state_in  = ST_ADV;
               end else begin
                  ires_in  = lo_ff + {1'b0, div_rem};
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Divider starts on the cycle the state enters ST_DIV
      if (state_ff == ST_ADV && mul_done && op_ff == lcgbr_pkg::OP_INT && !n_pow2) begin
         div_start = 1'b0;
      end
      if (div_go_ff) begin
         div_start = 1'b1;
      end
   end

   // Registered go signal so the divider sees the freshly registered draw bits
   assign div_go_in = (state_ff == ST_ADV) && mul_done && (op_ff == lcgbr_pkg::OP_INT)
                      && !n_pow2;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lcg_ff       <= lcgbr_pkg::LCG_MULT;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcg_ff       <= lcg_in;
         rsp_valid_ff <= rsp_valid_in;
         div_go_ff    <= div_go_in;
      end
      op_ff   <= op_in;
      lo_ff   <= lo_in;
      n_ff    <= n_in;
      bits_ff <= bits_in;
      ires_ff <= ires_in;
      frac_ff <= frac_in;
      bres_ff <= bres_in;
      err_ff  <= err_in;
      if (load_out) begin
         out_int_ff  <= ires_ff;
         out_frac_ff <= frac_ff;
         out_bool_ff <= bres_ff;
         out_err_ff  <= err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_int_result  = out_int_ff;
   assign rsp_fraction    = out_frac_ff;
   assign rsp_bool_result = out_bool_ff;
   assign rsp_error       = out_err_ff;

endmodule

`default_nettype wire

// ----- sv/lcgbr_checker.sv -----
// Port-level checker for lcg48_bounded_random_unit, with its bind statement.
// No package dependency; sees only the top-level ports.
`default_nettype none

module lcgbr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_int_result,
   input wire logic [23:0] rsp_fraction,
   input wire logic        rsp_bool_result,
   input wire logic        rsp_error
);

   // No response straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_int_result)
         && $stable(rsp_fraction) && $stable(rsp_bool_result) && $stable(rsp_error))
      else $error("stalled response changed");

   // The unit is busy on the cycle after it takes a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted request");

   // An error response carries no fraction or boolean
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_fraction == 24'd0 && !rsp_bool_result)
      else $error("error response with fraction or boolean set");

   // A true boolean implies a fraction above one half
   a_bool_frac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bool_result |-> rsp_fraction > 24'h80_0000)
      else $error("boolean true with fraction not above one half");

endmodule

bind lcg48_bounded_random_unit lcgbr_checker u_lcgbr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_int_result  (rsp_int_result),
   .rsp_fraction    (rsp_fraction),
   .rsp_bool_result (rsp_bool_result),
   .rsp_error       (rsp_error)
);

`default_nettype wire
